/* design/bvg_pkg.sv */
// Shared types, widths and constants of the battery voltage gauge.
`timescale 1ns / 1ps
package bvg_pkg;

  // Field widths
  localparam int MV_W      = 12;
  localparam int CODE_W    = 12;
  localparam int STEPPED_W = 13;
  localparam int PCT_W     = 14;
  localparam int BATT_W    = 16;
  localparam int SUM_W     = 20;
  localparam int PERIOD_W  = 16;
  localparam int COUNT_W   = 8;
  localparam int STEP_W    = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP          = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_MIN       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_MAX       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VBAT_EMPTY    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VBAT_FULL     = 4'd7;

  localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD = 16'd50;
  localparam logic [PERIOD_W-1:0] RST_REPORT_PERIOD = 16'd2000;
  localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT  = 8'd10;
  localparam logic [STEP_W-1:0]   RST_STEP          = 10'd100;
  localparam logic [MV_W-1:0]     RST_PIN_MIN       = 12'd576;
  localparam logic [MV_W-1:0]     RST_PIN_MAX       = 12'd1970;
  localparam logic [BATT_W-1:0]   RST_VBAT_EMPTY    = 16'd48000;
  localparam logic [BATT_W-1:0]   RST_VBAT_FULL     = 16'd56000;

  localparam logic [PCT_W-1:0] PCT_SCALE = 14'd10000;

  // Shared divider
  localparam int DIV_NUM_W = 28;
  localparam int DIV_DEN_W = 19;

  typedef enum logic [1:0] {
    DIV_SEL_Q,
    DIV_SEL_PCT,
    DIV_SEL_BAT
  } div_sel_t;

  typedef struct packed {
    logic     tick;
    logic     prep;
    logic     div_start;
    div_sel_t div_sel;
    logic     step;
    logic     clamp;
    logic     map;
    logic     cap_pct;
    logic     commit;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic report_hit;
    logic report_go;
    logic range_ok;
    logic div_done;
  } status_t;

endpackage

/* design/bvg_in_if.sv */
// Tick channel: one word per millisecond tick.
`timescale 1ns / 1ps
interface bvg_in_if import bvg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MV_W-1:0]   sample_mv;
  logic [CODE_W-1:0] raw_code;

  modport source (output valid, output sample_mv, output raw_code, input ready);
  modport sink   (input valid, input sample_mv, input raw_code, output ready);
endinterface

/* design/bvg_out_if.sv */
// Report channel: one word per tick with the held gauge values.
`timescale 1ns / 1ps
interface bvg_out_if import bvg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STEPPED_W-1:0] stepped_mv;
  logic [PCT_W-1:0]     percent_hundredths;
  logic [BATT_W-1:0]    battery_mv;
  logic [CODE_W-1:0]    latched_code;
  logic                 report_updated;

  modport source (output valid, output stepped_mv, output percent_hundredths,
                  output battery_mv, output latched_code, output report_updated,
                  input ready);
  modport sink   (input valid, input stepped_mv, input percent_hundredths,
                  input battery_mv, input latched_code, input report_updated,
                  output ready);
endinterface

/* design/bvg_cfg_if.sv */
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
interface bvg_cfg_if import bvg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/battery_voltage_gauge.sv */
// Battery voltage gauge top level: controller, datapath and channel wiring.
//
// Usage: each word on the tick channel is one millisecond tick with the pin
// voltage (sample_mv) and the raw converter code. For every accepted tick
// exactly one word leaves on the report channel with the held stepped pin
// voltage, charge in hundredths of a percent, battery millivolts, latched
// code and a flag that is set when this tick made a new report.
// Configuration words on the cfg channel (index 0..7) are always accepted;
// write them only while no tick is in flight.
// Sequence: a tick with no report evaluation goes from idle to the output
// stage; an evaluation that finds no change passes prepare and test first;
// a new report runs the shared one-bit-per-cycle divider for three 28-bit
// divisions (rounding, percent, battery voltage); empty pin range: rounding only.
// The tick channel takes one word at a time; it is ready again as soon as
// the result sits in the output register, so one tick can be accepted while
// the previous report word waits for the receiver. If the receiver stalls
// longer, the next result holds in the controller until the register frees.
// Synchronous reset restores the default configuration and clears all
// counters, sums and held values; report words carry zeros until the first report.
`timescale 1ns / 1ps
module battery_voltage_gauge import bvg_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  bvg_in_if.sink    tick,
  bvg_out_if.source report,
  bvg_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  bvg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .out_valid  (report.valid),
    .out_ready  (report.ready),
    .status     (status),
    .cmd        (cmd)
  );

  bvg_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg.valid && cfg.ready),
    .cfg_index          (cfg.index),
    .cfg_data           (cfg.data),
    .sample_mv          (tick.sample_mv),
    .raw_code           (tick.raw_code),
    .cmd                (cmd),
    .status             (status),
    .stepped_mv         (report.stepped_mv),
    .percent_hundredths (report.percent_hundredths),
    .battery_mv         (report.battery_mv),
    .latched_code       (report.latched_code),
    .report_updated     (report.report_updated)
  );

endmodule

/* design/bvg_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bvg_div import bvg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo,
  output logic [DIV_DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] trial;

  assign shifted = {rem, quo[DIV_NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      // shifted < 2*den, so a successful subtract fits the remainder
      if (!trial[DIV_DEN_W+1]) begin
        rem <= trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* design/bvg_datapath.sv */
// Gauge datapath: config registers, tick counters, averaging, report math.
`timescale 1ns / 1ps
module bvg_datapath import bvg_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [MV_W-1:0]       sample_mv,
  input  logic [CODE_W-1:0]     raw_code,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [STEPPED_W-1:0]  stepped_mv,
  output logic [PCT_W-1:0]      percent_hundredths,
  output logic [BATT_W-1:0]     battery_mv,
  output logic [CODE_W-1:0]     latched_code,
  output logic                  report_updated
);

  localparam int KEEP = (ADC_BITS < CODE_W) ? ADC_BITS : CODE_W;
  localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((32'd1 << KEEP) - 32'd1);
  localparam int Q_W    = 20;  // rounded quotient never exceeds the sum width
  localparam int STPD_W = 21;  // q * step before masking
  localparam int NST_W  = COUNT_W + STEP_W;
  localparam int LN_W   = STEPPED_W + COUNT_W;

  // Configuration
  logic [PERIOD_W-1:0] sample_period;
  logic [PERIOD_W-1:0] report_period;
  logic [COUNT_W-1:0]  sample_count;
  logic [STEP_W-1:0]   step;
  logic [MV_W-1:0]     pin_min;
  logic [MV_W-1:0]     pin_max;
  logic [BATT_W-1:0]   vbat_empty;
  logic [BATT_W-1:0]   vbat_full;

  // Gauge state
  logic [PERIOD_W-1:0]  tss;
  logic [PERIOD_W-1:0]  tsr;
  logic [SUM_W-1:0]     running_sum;
  logic [COUNT_W-1:0]   samples_taken;
  logic [SUM_W-1:0]     average_sum;
  logic [STEPPED_W-1:0] last_reported;
  logic                 has_reported;
  logic [STEPPED_W-1:0] held_stepped;
  logic [PCT_W-1:0]     held_percent;
  logic [BATT_W-1:0]    held_battery;
  logic [CODE_W-1:0]    held_code;
  logic                 updated;

  // Working registers
  logic [CODE_W-1:0]  code_hold;
  logic [COUNT_W-1:0] n_r;
  logic [STEP_W-1:0]  st_r;
  logic [NST_W-1:0]   nst;
  logic [LN_W-1:0]    ln;
  logic [STPD_W-1:0]  stepped;
  logic [MV_W-1:0]    off_r;
  logic [MV_W-1:0]    den_r;
  logic               range_ok;
  logic               bneg_r;
  logic [BATT_W-1:0]  bmag_r;
  logic [25:0]        p_pct;
  logic [27:0]        p_bat;
  logic [PCT_W-1:0]   pct_r;

  // Output register
  logic [STEPPED_W-1:0] out_stepped;
  logic [PCT_W-1:0]     out_percent;
  logic [BATT_W-1:0]    out_battery;
  logic [CODE_W-1:0]    out_code;
  logic                 out_updated;

  // Divider
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  // Combinational
  logic [PERIOD_W-1:0] tss_inc;
  logic [PERIOD_W-1:0] tsr_inc;
  logic                sample_hit;
  logic                report_hit;
  logic [SUM_W-1:0]    rs_add;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                avg_hit;
  logic [LN_W:0]       diff;
  logic [LN_W:0]       diff_neg;
  logic [LN_W-1:0]     abs_diff;
  logic [21:0]         qnum;
  logic [29:0]         prod_step;
  logic [MV_W-1:0]     clean;
  logic [BATT_W:0]     brange;
  logic [BATT_W:0]     brange_neg;
  logic [25:0]         prod_pct;
  logic [27:0]         prod_bat;
  logic [BATT_W-1:0]   batt_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= RST_SAMPLE_PERIOD;
      report_period <= RST_REPORT_PERIOD;
      sample_count  <= RST_SAMPLE_COUNT;
      step          <= RST_STEP;
      pin_min       <= RST_PIN_MIN;
      pin_max       <= RST_PIN_MAX;
      vbat_empty    <= RST_VBAT_EMPTY;
      vbat_full     <= RST_VBAT_FULL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period <= cfg_data;
        REG_REPORT_PERIOD: report_period <= cfg_data;
        REG_SAMPLE_COUNT:  sample_count  <= cfg_data[COUNT_W-1:0];
        REG_STEP:          step          <= cfg_data[STEP_W-1:0];
        REG_PIN_MIN:       pin_min       <= cfg_data[MV_W-1:0];
        REG_PIN_MAX:       pin_max       <= cfg_data[MV_W-1:0];
        REG_VBAT_EMPTY:    vbat_empty    <= cfg_data;
        REG_VBAT_FULL:     vbat_full     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tss_inc    = tss + PERIOD_W'(1);
  assign tsr_inc    = tsr + PERIOD_W'(1);
  assign sample_hit = (tss_inc >= sample_period);
  assign report_hit = (tsr_inc >= report_period);
  assign rs_add     = running_sum + SUM_W'(sample_mv);
  assign cnt_inc    = samples_taken + COUNT_W'(1);
  assign avg_hit    = (cnt_inc >= sample_count);

  // Hysteresis test on sums: |avg_sum - last * n| >= step * n
  assign diff     = {2'b00, average_sum} - {1'b0, ln};
  assign diff_neg = -diff;
  assign abs_diff = diff[LN_W] ? diff_neg[LN_W-1:0] : diff[LN_W-1:0];

  // Half-up rounding: (2s + n*st) / (2*n*st)
  assign qnum      = {1'b0, average_sum, 1'b0} + {4'b0000, nst};
  assign prod_step = {10'd0, div_quo[Q_W-1:0]} * {20'd0, st_r};

  always_comb begin
    if (stepped < {9'd0, pin_min}) begin
      clean = pin_min;
    end else if (stepped > {9'd0, pin_max}) begin
      clean = pin_max;
    end else begin
      clean = stepped[MV_W-1:0];
    end
  end

  assign brange     = {1'b0, vbat_full} - {1'b0, vbat_empty};
  assign brange_neg = -brange;
  assign prod_pct   = {14'd0, off_r} * {12'd0, PCT_SCALE};
  assign prod_bat   = {16'd0, off_r} * {12'd0, bmag_r};

  // Floor toward minus infinity when the battery range is reversed
  assign batt_val = bneg_r ? (vbat_empty - div_quo[BATT_W-1:0] - BATT_W'(|div_rem))
                           : (vbat_empty + div_quo[BATT_W-1:0]);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEL_Q: begin
        div_num = {6'd0, qnum};
        div_den = {nst, 1'b0};
      end
      DIV_SEL_PCT: begin
        div_num = {2'b00, p_pct};
        div_den = {7'd0, den_r};
      end
      DIV_SEL_BAT: begin
        div_num = p_bat;
        div_den = {7'd0, den_r};
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  bvg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tss           <= '0;
      tsr           <= '0;
      running_sum   <= '0;
      samples_taken <= '0;
      average_sum   <= '0;
      last_reported <= '0;
      has_reported  <= 1'b0;
      held_stepped  <= '0;
      held_percent  <= '0;
      held_battery  <= '0;
      held_code     <= '0;
      updated       <= 1'b0;
    end else begin
      if (cmd.tick) begin
        if (sample_hit) begin
          tss <= '0;
          if (avg_hit) begin
            average_sum   <= rs_add;
            running_sum   <= '0;
            samples_taken <= '0;
          end else begin
            running_sum   <= rs_add;
            samples_taken <= cnt_inc;
          end
        end else begin
          tss <= tss_inc;
        end
        tsr     <= report_hit ? '0 : tsr_inc;
        updated <= 1'b0;
      end
      if (cmd.commit) begin
        last_reported <= stepped[STEPPED_W-1:0];
        has_reported  <= 1'b1;
        held_stepped  <= stepped[STEPPED_W-1:0];
        held_percent  <= range_ok ? pct_r : '0;
        held_battery  <= range_ok ? batt_val : vbat_empty;
        held_code     <= code_hold;
        updated       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      code_hold <= raw_code & CODE_MASK;
      n_r       <= (sample_count == '0) ? COUNT_W'(1) : sample_count;
      st_r      <= (step == '0) ? STEP_W'(1) : step;
    end
    if (cmd.prep) begin
      nst <= {{STEP_W{1'b0}}, n_r} * {{COUNT_W{1'b0}}, st_r};
      ln  <= {{STEPPED_W{1'b0}}, n_r} * {{COUNT_W{1'b0}}, last_reported};
    end
    if (cmd.step) begin
      stepped <= prod_step[STPD_W-1:0];
    end
    if (cmd.clamp) begin
      off_r    <= clean - pin_min;
      den_r    <= pin_max - pin_min;
      range_ok <= (pin_max > pin_min);
      bneg_r   <= brange[BATT_W];
      bmag_r   <= brange[BATT_W] ? brange_neg[BATT_W-1:0] : brange[BATT_W-1:0];
    end
    if (cmd.map) begin
      p_pct <= prod_pct;
      p_bat <= prod_bat;
    end
    if (cmd.cap_pct) begin
      pct_r <= div_quo[PCT_W-1:0];
    end
    if (cmd.load_out) begin
      out_stepped <= held_stepped;
      out_percent <= held_percent;
      out_battery <= held_battery;
      out_code    <= held_code;
      out_updated <= updated;
    end
  end

  assign status.report_hit = report_hit;
  assign status.report_go  = !has_reported || ({3'b000, nst} <= abs_diff);
  assign status.range_ok   = range_ok;
  assign status.div_done   = div_done;

  assign stepped_mv         = out_stepped;
  assign percent_hundredths = out_percent;
  assign battery_mv         = out_battery;
  assign latched_code       = out_code;
  assign report_updated     = out_updated;

endmodule

/* design/bvg_ctrl.sv */
// Gauge controller: sequences one tick and the report evaluation.
`timescale 1ns / 1ps
module bvg_ctrl import bvg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tick_valid,
  output logic    tick_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_TEST,
    S_DIV_Q,
    S_CLAMP,
    S_MAP,
    S_PCT_GO,
    S_DIV_P,
    S_DIV_B,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign tick_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.tick   = 1'b1;
          state_next = status.report_hit ? S_PREP : S_DONE;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (status.report_go) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_Q;
          state_next    = S_DIV_Q;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV_Q: begin
        if (status.div_done) begin
          cmd.step   = 1'b1;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_MAP;
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        // empty pin range: skip both divisions
        state_next = status.range_ok ? S_PCT_GO : S_COMMIT;
      end
      S_PCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_PCT;
        state_next    = S_DIV_P;
      end
      S_DIV_P: begin
        if (status.div_done) begin
          cmd.cap_pct   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_BAT;
          state_next    = S_DIV_B;
        end
      end
      S_DIV_B: begin
        if (status.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/bvg_checker.sv */
// Port-level assertions for the battery voltage gauge, bound to the top level.
`timescale 1ns / 1ps
module bvg_checker import bvg_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             tick_valid,
  input logic             tick_ready,
  input logic             report_valid,
  input logic             report_ready,
  input logic [PCT_W-1:0] percent_hundredths
);

  // No result word is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("report valid after reset");

  // A stalled report word stays offered
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid)
    else $error("report word dropped while stalled");

  // One tick at a time: ready drops after a word is taken
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted on consecutive cycles");

  // Charge never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> percent_hundredths <= PCT_SCALE)
    else $error("percent above full scale");

endmodule

bind battery_voltage_gauge bvg_checker u_bvg_checker (
  .clk                (clk),
  .rst                (rst),
  .tick_valid         (tick.valid),
  .tick_ready         (tick.ready),
  .report_valid       (report.valid),
  .report_ready       (report.ready),
  .percent_hundredths (report.percent_hundredths)
);
